FILE: src/i2cmwr_pkg.sv
package i2cmwr_pkg;

    // Command codes carried by one input beat
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WRITE_COUNT = 2'd0;
    localparam logic [1:0] CFG_READ_COUNT  = 2'd1;
    localparam logic [1:0] CFG_LENGTH_MODE = 2'd2;
    localparam logic [1:0] CFG_PHASE_TICKS = 2'd3;

    // Transaction status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_NACK = 2'd2;

    // Read count assumed in length mode until the length byte arrives
    localparam logic [7:0] LEN_MODE_GUESS = 8'd100;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd200;

    typedef struct packed {
        logic [4:0]  write_count;
        logic [7:0]  read_count;
        logic        length_from_first;
        logic [15:0] phase_ticks;
    } cfg_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       busy_res;
        logic [1:0] status;
    } res_t;

endpackage

FILE: src/i2cmwr_seq.sv
module i2cmwr_seq
    import i2cmwr_pkg::*;
#(
    parameter int TX_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  cfg_t       cfg,
    input  logic [1:0] cmd,
    input  logic [7:0] tx_byte,
    input  logic [3:0] tx_slot,
    input  logic       sda_in,
    output res_t       res
);

    localparam int IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TX_DEPTH - 1);

    // Sequencer phase codes
    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_START_HOLD  = 4'd1;
    localparam logic [3:0] PH_WBIT_SETUP  = 4'd2;
    localparam logic [3:0] PH_WBIT_LOW    = 4'd3;
    localparam logic [3:0] PH_WACK_HIGH   = 4'd4;
    localparam logic [3:0] PH_WACK_SAMPLE = 4'd5;
    localparam logic [3:0] PH_NSTOP_HIGH  = 4'd6;
    localparam logic [3:0] PH_NSTOP_END   = 4'd7;
    localparam logic [3:0] PH_WACK_DONE   = 4'd8;
    localparam logic [3:0] PH_RBIT_HIGH   = 4'd9;
    localparam logic [3:0] PH_RBIT_SAMPLE = 4'd10;
    localparam logic [3:0] PH_RACK_HIGH   = 4'd11;
    localparam logic [3:0] PH_RACK_LOW    = 4'd12;
    localparam logic [3:0] PH_RACK_END    = 4'd13;
    localparam logic [3:0] PH_STOP_HIGH   = 4'd14;
    localparam logic [3:0] PH_STOP_END    = 4'd15;

    logic [7:0] store_mem [TX_DEPTH];

    logic [3:0]       phase_reg, phase_next;
    logic [15:0]      tick_reg, tick_next;
    logic [1:0]       left_reg, left_next;
    logic [2:0]       bit_reg, bit_next;
    logic [8:0]       byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       total_reg, total_next;
    logic             scl_reg, scl_next;
    logic             sdal_reg, sdal_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_reg;
    logic             hit_reg;
    logic [7:0]       fwd_reg;
    logic [7:0]       rd_reg;

    logic             slot_ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             load_now;
    logic             do_nsec;
    logic [15:0]      pt_eff;
    logic [7:0]       eff_shift;
    logic [7:0]       rx_byte;
    logic [2:0]       bit_inc;
    logic [7:0]       nsec_total;

    assign slot_ok = int'(tx_slot) < TX_DEPTH;
    assign wr_en   = (cmd == CMD_LOAD) && slot_ok;
    assign wr_addr = IDX_W'(tx_slot);
    assign pt_eff  = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    assign bit_inc = bit_reg + 3'd1;

    // Shift value: a pending store read resolves here, with same-beat write forwarded
    assign eff_shift = pend_reg ? (hit_reg ? fwd_reg : rd_reg) : shift_reg;
    assign rx_byte   = {eff_shift[6:0], sda_in};
    assign nsec_total = cfg.length_from_first ? LEN_MODE_GUESS : cfg.read_count;

    // Next-state logic for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        left_next  = left_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = eff_shift;
        total_next = total_reg;
        scl_next   = scl_reg;
        sdal_next  = sdal_reg;
        idx_next   = idx_reg;
        load_now   = 1'b0;
        do_nsec    = 1'b0;
        res.rx_valid = 1'b0;
        res.rx_data  = 8'd0;
        res.status   = ST_NONE;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd == CMD_START)
            begin
                scl_next   = 1'b1;
                sdal_next  = 1'b1;
                phase_next = PH_START_HOLD;
                left_next  = 2'd1;
                tick_next  = pt_eff;
            end
        end
        else if (tick_reg > 16'd1)
        begin
            tick_next = tick_reg - 16'd1;
        end
        else if (left_reg > 2'd1)
        begin
            left_next = left_reg - 2'd1;
            tick_next = pt_eff;
        end
        else
        begin
            unique case (phase_reg)
                PH_START_HOLD:
                begin
                    scl_next  = 1'b0;
                    byte_next = 9'd0;
                    idx_next  = '0;
                    do_nsec   = 1'b1;
                end
                PH_WBIT_SETUP:
                begin
                    sdal_next  = ~eff_shift[7];
                    scl_next   = 1'b1;
                    phase_next = PH_WBIT_LOW;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_WBIT_LOW:
                begin
                    scl_next   = 1'b0;
                    shift_next = {eff_shift[6:0], 1'b0};
                    bit_next   = bit_inc;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                    if (bit_inc == 3'd0)
                    begin
                        sdal_next  = 1'b0;
                        phase_next = PH_WACK_HIGH;
                    end
                    else
                    begin
                        phase_next = PH_WBIT_SETUP;
                    end
                end
                PH_WACK_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WACK_SAMPLE;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_WACK_SAMPLE:
                begin
                    scl_next   = 1'b0;
                    sdal_next  = 1'b1;
                    phase_next = sda_in ? PH_NSTOP_HIGH : PH_WACK_DONE;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_NSTOP_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_NSTOP_END;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_NSTOP_END:
                begin
                    sdal_next  = 1'b0;
                    phase_next = PH_IDLE;
                    res.status = ST_NACK;
                end
                PH_WACK_DONE:
                begin
                    sdal_next = 1'b1;
                    byte_next = byte_reg + 9'd1;
                    idx_next  = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
                    do_nsec   = 1'b1;
                end
                PH_RBIT_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RBIT_SAMPLE;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_RBIT_SAMPLE:
                begin
                    shift_next = rx_byte;
                    scl_next   = 1'b0;
                    bit_next   = bit_inc;
                    phase_next = PH_RBIT_HIGH;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                    if (bit_inc == 3'd0)
                    begin
                        res.rx_valid = 1'b1;
                        res.rx_data  = rx_byte;
                        phase_next   = PH_RACK_HIGH;
                        // Last byte gets NACK, others ACK
                        if (({1'b0, byte_reg} + 10'd1) == {2'b00, total_reg})
                        begin
                            sdal_next = 1'b0;
                            left_next = 2'd1;
                        end
                        else
                        begin
                            sdal_next = 1'b1;
                            left_next = 2'd2;
                        end
                        if ((byte_reg == 9'd0) && cfg.length_from_first)
                        begin
                            total_next = rx_byte;
                        end
                    end
                end
                PH_RACK_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RACK_LOW;
                    left_next  = 2'd3;
                    tick_next  = pt_eff;
                end
                PH_RACK_LOW:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_RACK_END;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_RACK_END:
                begin
                    byte_next = byte_reg + 9'd1;
                    left_next = 2'd1;
                    tick_next = pt_eff;
                    if ((byte_reg + 9'd1) < {1'b0, total_reg})
                    begin
                        sdal_next  = 1'b0;
                        shift_next = 8'd0;
                        bit_next   = 3'd0;
                        phase_next = PH_RBIT_HIGH;
                    end
                    else
                    begin
                        sdal_next  = 1'b1;
                        phase_next = PH_STOP_HIGH;
                    end
                end
                PH_STOP_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_STOP_END;
                    left_next  = 2'd1;
                    tick_next  = pt_eff;
                end
                PH_STOP_END:
                begin
                    sdal_next  = 1'b0;
                    phase_next = PH_IDLE;
                    res.status = ST_OK;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Next section: another write byte, else reads, else STOP
        if (do_nsec)
        begin
            left_next = 2'd1;
            tick_next = pt_eff;
            if (byte_next < {4'b0000, cfg.write_count})
            begin
                load_now   = 1'b1;
                bit_next   = 3'd0;
                phase_next = PH_WBIT_SETUP;
            end
            else
            begin
                total_next = nsec_total;
                byte_next  = 9'd0;
                if (nsec_total != 8'd0)
                begin
                    sdal_next  = 1'b0;
                    shift_next = 8'd0;
                    bit_next   = 3'd0;
                    phase_next = PH_RBIT_HIGH;
                end
                else
                begin
                    sdal_next  = 1'b1;
                    phase_next = PH_STOP_HIGH;
                end
            end
        end

        res.scl_level    = scl_next;
        res.sda_pull_low = sdal_next;
        res.busy_res     = (phase_next != PH_IDLE);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 16'd0;
            left_reg  <= 2'd0;
            bit_reg   <= 3'd0;
            byte_reg  <= 9'd0;
            shift_reg <= 8'd0;
            total_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sdal_reg  <= 1'b0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            left_reg  <= left_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            total_reg <= total_next;
            scl_reg   <= scl_next;
            sdal_reg  <= sdal_next;
            idx_reg   <= idx_next;
            pend_reg  <= load_now;
        end
    end

    // Transmit store: read-first, one write and one registered read per beat
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (wr_en)
            begin
                store_mem[wr_addr] <= tx_byte;
            end
            if (load_now)
            begin
                rd_reg  <= store_mem[idx_next];
                hit_reg <= wr_en && (wr_addr == idx_next);
                fwd_reg <= tx_byte;
            end
        end
    end

    // A pending store read is only ever consumed by the bit setup phase
    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (phase_reg == PH_WBIT_SETUP))
        else $error("store read pending outside bit setup");

    // Any active phase is mid-wait with non-zero counters
    a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> ((tick_reg != 16'd0) && (left_reg != 2'd0)))
        else $error("active phase with empty wait");

    // A received byte only comes out of the read sample phase
    a_rx_src: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.rx_valid) |-> (phase_reg == PH_RBIT_SAMPLE))
        else $error("rx byte outside read sample");

    // Final status only on the beat the transaction ends
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res.status != ST_NONE)) |=> (phase_reg == PH_IDLE))
        else $error("status reported while still busy");

endmodule

FILE: src/i2c_master_write_read_unit.sv
// A beat's result is registered in the output stage before it is offered.
// One beat per cycle while in_ready is high; each beat is one bus tick through the sequencer,
// with the transmit store read registered and forwarded into the following beat.
// A two-entry output stage keeps input ready high while one result waits downstream.
// Reset (rst_n, asynchronous, active low): sequencer idle, SCL high, SDA released,
// configuration to its reset values; transmit store contents undefined until loaded.
module i2c_master_write_read_unit
    import i2cmwr_pkg::*;
#(
    parameter int TX_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  tx_byte,
    input  logic [3:0]  tx_slot,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic        rx_valid,
    output logic [7:0]  rx_data,
    output logic        busy_res,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    res_t res;
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic in_fire;
    logic out_free;

    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_count       <= 5'd0;
            cfg_reg.read_count        <= 8'd0;
            cfg_reg.length_from_first <= 1'b0;
            cfg_reg.phase_ticks       <= PHASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WRITE_COUNT: cfg_reg.write_count       <= cfg_data[4:0];
                CFG_READ_COUNT:  cfg_reg.read_count        <= cfg_data[7:0];
                CFG_LENGTH_MODE: cfg_reg.length_from_first <= cfg_data[0];
                CFG_PHASE_TICKS: cfg_reg.phase_ticks       <= cfg_data;
            endcase
        end
    end

    i2cmwr_seq #(
        .TX_DEPTH (TX_DEPTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_fire),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .tx_byte (tx_byte),
        .tx_slot (tx_slot),
        .sda_in  (sda_in),
        .res     (res)
    );

    // Output stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = out_reg.scl_level;
    assign sda_pull_low = out_reg.sda_pull_low;
    assign rx_valid     = out_reg.rx_valid;
    assign rx_data      = out_reg.rx_data;
    assign busy_res     = out_reg.busy_res;
    assign status       = out_reg.status;

    // Skid entry only ever sits behind a full output register
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat without output beat");

    // A stalled output with a full skid entry takes no new beat
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("skid beat lost while output stalled");

endmodule

FILE: tb/i2cmwr_checker.sv
module i2cmwr_checker
    import i2cmwr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  tx_byte,
    input  logic [3:0]  tx_slot,
    input  logic        sda_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        scl_level,
    input  logic        sda_pull_low,
    input  logic        rx_valid,
    input  logic [7:0]  rx_data,
    input  logic        busy_res,
    input  logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output logic        seq_busy,
    output logic        tx_phase,
    output logic        rd_first,
    output logic [2:0]  rd_bit
);
    timeunit 1ns;
    timeprecision 1ps;

    // Bus sequencer steps, one per kind of line edge
    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_WB_SETUP,
        SEQ_WB_LOW,
        SEQ_WACK_HIGH,
        SEQ_WACK_SAMPLE,
        SEQ_NSTOP_HIGH,
        SEQ_NSTOP_END,
        SEQ_WACK_DONE,
        SEQ_RB_HIGH,
        SEQ_RB_SAMPLE,
        SEQ_RACK_HIGH,
        SEQ_RACK_LOW,
        SEQ_RACK_END,
        SEQ_STOP_HIGH,
        SEQ_STOP_END
    } seq_e;

    // Shadow of the block's registers and bus state
    cfg_t        shadow;
    logic [7:0]  tx_mem [16];
    seq_e        ph;
    logic [15:0] tick_cnt;
    logic [1:0]  phases_rem;
    logic [2:0]  bit_cnt;
    logic [8:0]  byte_cnt;
    logic [7:0]  shreg;
    logic [7:0]  rd_total;
    logic        scl;
    logic        sda_lo;

    res_t        due_lines [$];
    res_t        got;
    res_t        want;
    int          fails_n;

    function automatic logic [15:0] phase_len();
        return (shadow.phase_ticks == 16'd0) ? 16'd1 : shadow.phase_ticks;
    endfunction

    task automatic hold(input seq_e nxt, input logic [1:0] n);
        ph = nxt;
        phases_rem = n;
        tick_cnt = phase_len();
    endtask

    task automatic go_stop();
        sda_lo = 1'b1;
        hold(SEQ_STOP_HIGH, 2'd1);
    endtask

    task automatic go_read();
        sda_lo = 1'b0;
        shreg = 8'd0;
        bit_cnt = 3'd0;
        hold(SEQ_RB_HIGH, 2'd1);
    endtask

    // Next write byte, or switch over to the read section, or to the STOP when there are no reads
    task automatic go_next();
        if (byte_cnt < shadow.write_count) begin
            shreg = tx_mem[byte_cnt[3:0]];
            bit_cnt = 3'd0;
            hold(SEQ_WB_SETUP, 2'd1);
        end
        else begin
            sda_lo = 1'b0;
            rd_total = shadow.length_from_first ? LEN_MODE_GUESS : shadow.read_count;
            byte_cnt = 9'd0;
            if (rd_total != 8'd0)
                go_read();
            else
                go_stop();
        end
    endtask

    // One bus tick: the line levels and events that the beat should produce
    task automatic bus_tick(input logic [1:0] c, input logic [7:0] b, input logic [3:0] s,
                            input logic sd, output res_t r);
        r = '0;
        if (c == CMD_LOAD)
            tx_mem[s] = b;

        if (ph == SEQ_IDLE) begin
            if (c == CMD_START) begin
                scl = 1'b1;
                sda_lo = 1'b1;
                hold(SEQ_START, 2'd1);
            end
        end
        else if (tick_cnt > 16'd1) begin
            tick_cnt = tick_cnt - 16'd1;
        end
        else if (phases_rem > 2'd1) begin
            phases_rem = phases_rem - 2'd1;
            tick_cnt = phase_len();
        end
        else begin
            case (ph)
                SEQ_START:
                begin
                    scl = 1'b0;
                    byte_cnt = 9'd0;
                    go_next();
                end
                SEQ_WB_SETUP:
                begin
                    sda_lo = ~shreg[7];
                    scl = 1'b1;
                    hold(SEQ_WB_LOW, 2'd1);
                end
                SEQ_WB_LOW:
                begin
                    scl = 1'b0;
                    shreg = shreg << 1;
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt == 3'd0) begin
                        sda_lo = 1'b0;
                        hold(SEQ_WACK_HIGH, 2'd1);
                    end
                    else begin
                        hold(SEQ_WB_SETUP, 2'd1);
                    end
                end
                SEQ_WACK_HIGH:
                begin
                    scl = 1'b1;
                    hold(SEQ_WACK_SAMPLE, 2'd1);
                end
                SEQ_WACK_SAMPLE:
                begin
                    // slave ACK is SDA low; high means abandon with a STOP
                    scl = 1'b0;
                    sda_lo = 1'b1;
                    if (sd)
                        hold(SEQ_NSTOP_HIGH, 2'd1);
                    else
                        hold(SEQ_WACK_DONE, 2'd1);
                end
                SEQ_NSTOP_HIGH:
                begin
                    scl = 1'b1;
                    hold(SEQ_NSTOP_END, 2'd1);
                end
                SEQ_NSTOP_END:
                begin
                    sda_lo = 1'b0;
                    ph = SEQ_IDLE;
                    r.status = ST_NACK;
                end
                SEQ_WACK_DONE:
                begin
                    sda_lo = 1'b1;
                    byte_cnt = byte_cnt + 9'd1;
                    go_next();
                end
                SEQ_RB_HIGH:
                begin
                    scl = 1'b1;
                    hold(SEQ_RB_SAMPLE, 2'd1);
                end
                SEQ_RB_SAMPLE:
                begin
                    shreg = {shreg[6:0], sd};
                    scl = 1'b0;
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt != 3'd0) begin
                        hold(SEQ_RB_HIGH, 2'd1);
                    end
                    else begin
                        r.rx_valid = 1'b1;
                        r.rx_data = shreg;
                        // last byte gets NACK, others ACK with a longer low phase
                        if (int'(byte_cnt) + 1 == int'(rd_total)) begin
                            sda_lo = 1'b0;
                            hold(SEQ_RACK_HIGH, 2'd1);
                        end
                        else begin
                            sda_lo = 1'b1;
                            hold(SEQ_RACK_HIGH, 2'd2);
                        end
                        if (byte_cnt == 9'd0 && shadow.length_from_first)
                            rd_total = shreg;
                    end
                end
                SEQ_RACK_HIGH:
                begin
                    scl = 1'b1;
                    hold(SEQ_RACK_LOW, 2'd3);
                end
                SEQ_RACK_LOW:
                begin
                    scl = 1'b0;
                    hold(SEQ_RACK_END, 2'd1);
                end
                SEQ_RACK_END:
                begin
                    sda_lo = 1'b0;
                    byte_cnt = byte_cnt + 9'd1;
                    if (byte_cnt < rd_total)
                        go_read();
                    else
                        go_stop();
                end
                SEQ_STOP_HIGH:
                begin
                    scl = 1'b1;
                    hold(SEQ_STOP_END, 2'd1);
                end
                SEQ_STOP_END:
                begin
                    sda_lo = 1'b0;
                    ph = SEQ_IDLE;
                    r.status = ST_OK;
                end
                default:
                begin
                    ph = SEQ_IDLE;
                end
            endcase
        end

        r.scl_level = scl;
        r.sda_pull_low = sda_lo;
        r.busy_res = (ph != SEQ_IDLE);
    endtask

    task automatic flag(input string why);
        fails_n++;
        if (fails_n <= 10)
            $display("%0t ns: %s", $time, why);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow.write_count = '0;
            shadow.read_count = '0;
            shadow.length_from_first = 1'b0;
            shadow.phase_ticks = PHASE_TICKS_RESET;
            for (int i = 0; i < 16; i++)
                tx_mem[i] = 8'd0;
            ph = SEQ_IDLE;
            tick_cnt = '0;
            phases_rem = '0;
            bit_cnt = '0;
            byte_cnt = '0;
            shreg = '0;
            rd_total = '0;
            scl = 1'b1;
            sda_lo = 1'b0;
            due_lines.delete();
            fails_n = 0;
            fail_count <= 0;
            pending <= 0;
            seq_busy <= 1'b0;
            tx_phase <= 1'b0;
            rd_first <= 1'b0;
            rd_bit <= 3'd0;
        end
        else begin
            // result beat against the oldest expectation
            if (out_valid && out_ready) begin
                got.scl_level = scl_level;
                got.sda_pull_low = sda_pull_low;
                got.rx_valid = rx_valid;
                got.rx_data = rx_data;
                got.busy_res = busy_res;
                got.status = status;
                if (due_lines.size() == 0) begin
                    flag($sformatf("result beat with nothing outstanding: scl %0d sda_low %0d",
                                   got.scl_level, got.sda_pull_low));
                end
                else begin
                    want = due_lines.pop_front();
                    if (got.scl_level !== want.scl_level
                        || got.sda_pull_low !== want.sda_pull_low
                        || got.rx_valid !== want.rx_valid
                        || got.rx_data !== want.rx_data
                        || got.busy_res !== want.busy_res
                        || got.status !== want.status)
                        flag($sformatf({"mismatch (exp/got): scl %0d/%0d sda_low %0d/%0d ",
                                        "rx_valid %0d/%0d rx_data %0h/%0h busy %0d/%0d ",
                                        "status %0d/%0d"},
                                       want.scl_level, got.scl_level,
                                       want.sda_pull_low, got.sda_pull_low,
                                       want.rx_valid, got.rx_valid,
                                       want.rx_data, got.rx_data,
                                       want.busy_res, got.busy_res,
                                       want.status, got.status));
                end
            end

            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WRITE_COUNT: shadow.write_count = cfg_data[4:0];
                    CFG_READ_COUNT:  shadow.read_count = cfg_data[7:0];
                    CFG_LENGTH_MODE: shadow.length_from_first = cfg_data[0];
                    CFG_PHASE_TICKS: shadow.phase_ticks = cfg_data;
                    default:         ;
                endcase
            end

            // input beat: one tick, one expected result
            if (in_valid && in_ready) begin
                bus_tick(cmd, tx_byte, tx_slot, sda_in, want);
                due_lines.push_back(want);
            end

            fail_count <= fails_n;
            pending <= due_lines.size();
            seq_busy <= (ph != SEQ_IDLE);
            tx_phase <= (ph == SEQ_START) || (ph == SEQ_WB_SETUP) || (ph == SEQ_WB_LOW)
                        || (ph == SEQ_WACK_HIGH) || (ph == SEQ_WACK_SAMPLE)
                        || (ph == SEQ_WACK_DONE);
            rd_first <= ((ph == SEQ_RB_HIGH) || (ph == SEQ_RB_SAMPLE)) && (byte_cnt == 9'd0);
            rd_bit <= bit_cnt;
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cmwr_pkg::*;

    // cmd value with no meaning of its own, a plain tick
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int ITEM_GOAL  = 1750;
    localparam int HOLD_AFTER = 500;
    localparam int LONG_HOLD  = 400;
    localparam int TAIL       = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  tx_byte;
    logic [3:0]  tx_slot;
    logic        sda_in;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        scl_level;
    logic        sda_pull_low;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        busy_res;
    logic [1:0]  status;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          chk_fails;
    int          chk_pending;
    logic        chk_busy;
    logic        chk_tx_phase;
    logic        chk_rd_first;
    logic [2:0]  chk_rd_bit;

    // stimulus knobs
    bit          gaps_on = 1'b1;
    bit          len_on = 1'b0;
    int          nack_pct = 0;
    logic [7:0]  len_byte = 8'd0;
    int          n_sent = 0;
    int          n_taken = 0;
    int          rx_wait = 0;

    always #5 clk = ~clk;

    i2c_master_write_read_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .tx_byte      (tx_byte),
        .tx_slot      (tx_slot),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_level    (scl_level),
        .sda_pull_low (sda_pull_low),
        .rx_valid     (rx_valid),
        .rx_data      (rx_data),
        .busy_res     (busy_res),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    i2cmwr_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .tx_byte      (tx_byte),
        .tx_slot      (tx_slot),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_level    (scl_level),
        .sda_pull_low (sda_pull_low),
        .rx_valid     (rx_valid),
        .rx_data      (rx_data),
        .busy_res     (busy_res),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (chk_fails),
        .pending      (chk_pending),
        .seq_busy     (chk_busy),
        .tx_phase     (chk_tx_phase),
        .rd_first     (chk_rd_first),
        .rd_bit       (chk_rd_bit)
    );

    // idle cycles before a beat: none while gaps_on is clear, else mostly none
    function automatic int draw_gap();
        if (!gaps_on || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // Result side: random stalls, plus one long hold-off to back the block up
    always @(posedge clk) begin : receiver
        int g;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end
        else if (out_valid && out_ready) begin
            n_taken <= n_taken + 1;
            if (n_taken == HOLD_AFTER) begin
                rx_wait <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else begin
                g = draw_gap();
                rx_wait <= g;
                out_ready <= (g == 0);
            end
        end
        else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // One input beat. SDA follows the bus section: ACK bits mostly low,
    // the length byte from len_byte, plain read bits random.
    task automatic push_beat(input logic [1:0] c, input logic [7:0] b, input logic [3:0] s);
        int   g;
        logic sd;
        g = draw_gap();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        if (chk_tx_phase)
            sd = ($urandom_range(0, 99) < nack_pct);
        else if (len_on && chk_rd_first)
            sd = len_byte[3'd7 - chk_rd_bit];
        else
            sd = ($urandom_range(0, 1) != 0);
        in_valid <= 1'b1;
        cmd <= c;
        tx_byte <= b;
        tx_slot <= s;
        sda_in <= sd;
        n_sent++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Tick until the transaction is over and every result is back
    task automatic drain();
        do begin
            while (chk_busy)
                push_beat(CMD_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            in_valid <= 1'b0;
            @(posedge clk);
            while (chk_pending != 0) @(posedge clk);
        end while (chk_busy);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // One setting: program all registers, open a transaction, random beats, drain
    task automatic run_phase(input int wc, input int rc, input bit lm, input int pt,
                             input int n, input int nk, input logic [7:0] lb);
        logic [1:0] c;
        int         r;
        write_reg(CFG_WRITE_COUNT, 16'(wc));
        write_reg(CFG_READ_COUNT, 16'(rc));
        write_reg(CFG_LENGTH_MODE, 16'(lm));
        write_reg(CFG_PHASE_TICKS, 16'(pt));
        cfg_we <= 1'b0;
        len_on = lm;
        nack_pct = nk;
        len_byte = lb;
        push_beat(CMD_START, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                c = CMD_LOAD;
            else if (r < 9)
                c = CMD_SPARE;
            else if (r < 12 || (!chk_busy && r < 40))
                c = CMD_START;
            else
                c = CMD_TICK;
            push_beat(c, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        end
        drain();
    endtask

    initial begin : stimulus
        logic [7:0] b;
        in_valid <= 1'b0;
        cmd <= CMD_TICK;
        tx_byte <= 8'd0;
        tx_slot <= 4'd0;
        sda_in <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_WRITE_COUNT;
        cfg_data <= 16'd0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole transmit store, byte extremes first
        for (int i = 0; i < 16; i++) begin
            case (i)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'h80;
                3:       b = 8'h01;
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_beat(CMD_LOAD, b, 4'(i));
        end
        push_beat(CMD_SPARE, 8'hFF, 4'hF);
        // transaction at reset settings, then a start and a load while busy
        push_beat(CMD_START, 8'h00, 4'h0);
        push_beat(CMD_START, 8'hA5, 4'h7);
        push_beat(CMD_LOAD, 8'h5A, 4'hF);
        push_beat(CMD_TICK, 8'hC3, 4'h9);
        drain();

        // directed settings: zero ticks, no reads, no writes, whole store and wrap,
        // heavy NACK, length byte 0, 1 and 3, a longer plain read
        run_phase(1, 1, 1'b0, 0, 40, 0, 8'd0);
        run_phase(2, 0, 1'b0, 1, 40, 0, 8'd0);
        run_phase(0, 3, 1'b0, 1, 40, 0, 8'd0);
        run_phase(17, 1, 1'b0, 1, 100, 0, 8'd0);
        run_phase(3, 2, 1'b0, 1, 100, 50, 8'd0);
        run_phase(1, 0, 1'b1, 1, 60, 0, 8'd0);
        run_phase(1, 0, 1'b1, 1, 60, 0, 8'd1);
        run_phase(2, 9, 1'b1, 1, 80, 0, 8'd3);
        run_phase(0, 6, 1'b0, 1, 40, 0, 8'd0);

        // random settings, mostly short phases and small counts
        while (n_sent < ITEM_GOAL) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            run_phase(($urandom_range(0, 7) == 0) ? 16 : $urandom_range(0, 4),
                      $urandom_range(0, 6),
                      1'($urandom_range(0, 1)),
                      ($urandom_range(0, 5) == 0) ? $urandom_range(3, 5)
                                                  : $urandom_range(0, 2),
                      $urandom_range(60, 140),
                      $urandom_range(0, 20),
                      8'($urandom_range(0, 10)));
        end

        repeat (TAIL) @(posedge clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("i2c_master_write_read_unit verification clean");
        else
            $display("i2c_master_write_read_unit verification failed");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #30000000;
        $display("i2c_master_write_read_unit verification failed");
        $finish;
    end

endmodule
